FILE: sv/brj_pkg.sv
// ----------------------------------------------------------------------------
// brj_pkg: shared types and codes of the bounded replay journal
// Field widths, register indexes, action and status codes, reset values of
// the budget registers and the layout of one stored journal entry.
// ----------------------------------------------------------------------------
package brj_pkg;

  // Default sizing of the journal core
  localparam int BRJ_DEPTH    = 16;
  localparam int BRJ_SEQ_BITS = 32;

  // Port field widths
  localparam int ACTION_W = 2;
  localparam int HANDLE_W = 32;
  localparam int BYTES_W  = 16;
  localparam int SEQ_W    = 32;
  localparam int STATUS_W = 4;
  localparam int COUNT_W  = 5;
  localparam int TOTAL_W  = 21;
  localparam int MAXE_W   = 5;
  localparam int MAXB_W   = 20;
  localparam int CFG_W    = 32;
  localparam int CFG_IDX_W = 2;

  // Budget register reset values
  localparam int MAX_ENTRIES_RST = 16;
  localparam int MAX_BYTES_RST   = 65536;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_ENTRIES = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_BYTES   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_INIT_SEQ    = 2'd2;

  // Request actions
  localparam logic [ACTION_W-1:0] ACT_APPEND     = 2'd0;
  localparam logic [ACTION_W-1:0] ACT_REPLAY     = 2'd1;
  localparam logic [ACTION_W-1:0] ACT_INVALIDATE = 2'd2;

  // Result status codes
  localparam logic [STATUS_W-1:0] ST_APPENDED        = 4'd0;
  localparam logic [STATUS_W-1:0] ST_NOT_RETAINED    = 4'd1;
  localparam logic [STATUS_W-1:0] ST_SEQ_OVERFLOW    = 4'd2;
  localparam logic [STATUS_W-1:0] ST_INVALID         = 4'd3;
  localparam logic [STATUS_W-1:0] ST_REPLAY_OK       = 4'd4;
  localparam logic [STATUS_W-1:0] ST_FUTURE          = 4'd5;
  localparam logic [STATUS_W-1:0] ST_GAP             = 4'd6;
  localparam logic [STATUS_W-1:0] ST_INVALIDATED     = 4'd7;
  localparam logic [STATUS_W-1:0] ST_INVALIDATE_AT_MAX = 4'd8;

  // One stored journal entry
  typedef struct packed {
    logic [HANDLE_W-1:0] handle;
    logic [BYTES_W-1:0]  size;
  } entry_t;

endpackage

FILE: sv/brj_entry_ram.sv
// ----------------------------------------------------------------------------
// brj_entry_ram: journal entry store
// Ring of record handles and sizes; one write port and one read port with
// registered read data that holds until the next read.
// ----------------------------------------------------------------------------
module brj_entry_ram #(
  parameter int DEPTH = brj_pkg::BRJ_DEPTH,
  localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic                clk,
  input  logic                we,
  input  logic [IDX_W-1:0]    waddr,
  input  brj_pkg::entry_t     wdata,
  input  logic                re,
  input  logic [IDX_W-1:0]    raddr,
  output brj_pkg::entry_t     rdata
);
  import brj_pkg::*;

  entry_t mem [DEPTH];

  // Write the appended entry
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Read on request, hold otherwise
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

FILE: sv/bounded_replay_journal_core.sv
// Flow: the request beat is latched, then decoded; an append evicts the oldest
//   entries first as its budget needs, and a replay reads each record from the
//   read port before it is registered. A new request is taken only once the
//   journal is idle again, after the previous result has been loaded.
// Reset: the journal is empty, budgets are 16 entries and 65536 bytes, the
//   current sequence and replay floor are 0; the entry store is not cleared.
// ----------------------------------------------------------------------------
// bounded_replay_journal_core: sequence-numbered replay journal
// Appends records under an entry and byte budget, evicting the oldest, replays
// every retained record newer than a given sequence, and invalidates.
// ----------------------------------------------------------------------------
module bounded_replay_journal_core #(
  parameter int DEPTH    = brj_pkg::BRJ_DEPTH,
  parameter int SEQ_BITS = brj_pkg::BRJ_SEQ_BITS
) (
  input  logic                              clk,
  input  logic                              rst,
  // configuration write port
  input  logic                              cfg_we,
  input  logic [brj_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [brj_pkg::CFG_W-1:0]         cfg_data,
  // request channel
  input  logic                              req_valid,
  output logic                              req_stall,
  input  logic [brj_pkg::ACTION_W-1:0]      action,
  input  logic                              record_present,
  input  logic [brj_pkg::HANDLE_W-1:0]      record_handle,
  input  logic [brj_pkg::BYTES_W-1:0]       record_bytes,
  input  logic [brj_pkg::SEQ_W-1:0]         after_sequence,
  // result channel
  output logic                              res_valid,
  input  logic                              res_stall,
  output logic [brj_pkg::STATUS_W-1:0]      status,
  output logic [brj_pkg::SEQ_W-1:0]         sequence_res,
  output logic                              record_valid,
  output logic [brj_pkg::HANDLE_W-1:0]      record_out,
  output logic [brj_pkg::SEQ_W-1:0]         current_sequence,
  output logic [brj_pkg::SEQ_W-1:0]         replay_floor,
  output logic [brj_pkg::COUNT_W-1:0]       retained_count,
  output logic [brj_pkg::TOTAL_W-1:0]       retained_bytes,
  output logic                              last
);
  import brj_pkg::*;

  localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam int SUM_W = CNT_W + 1;
  localparam int CAP_W = (CNT_W + 1 > MAXE_W) ? CNT_W + 1 : MAXE_W;
  localparam int CW    = (SEQ_BITS > SEQ_W) ? SEQ_BITS : SEQ_W;

  typedef enum logic [2:0] {
    S_IDLE,
    S_DECODE,
    S_EVICT_CHK,
    S_EVICT,
    S_REPLAY_RD,
    S_REPLAY_OUT
  } state_t;

  // Control state
  state_t               state, state_next;
  logic [MAXE_W-1:0]    max_entries, max_entries_next;
  logic [MAXB_W-1:0]    max_bytes, max_bytes_next;
  logic [SEQ_BITS-1:0]  current_seq, current_seq_next;
  logic [SEQ_BITS-1:0]  floor_seq, floor_seq_next;
  logic                 unavail, unavail_next;
  logic [IDX_W-1:0]     head, head_next;
  logic [CNT_W-1:0]     count, count_next;
  logic [TOTAL_W-1:0]   total, total_next;
  logic [CNT_W-1:0]     k, k_next;
  logic                 res_valid_next;

  // Latched request beat
  logic [ACTION_W-1:0]  req_action;
  logic                 req_present;
  logic [HANDLE_W-1:0]  req_handle;
  logic [BYTES_W-1:0]   req_bytes;
  logic [SEQ_W-1:0]     req_after;

  // Result being loaded
  logic                 out_load;
  logic [STATUS_W-1:0]  emit_status;
  logic [SEQ_W-1:0]     emit_seq;
  logic                 emit_valid;
  logic [HANDLE_W-1:0]  emit_handle;
  logic                 emit_last;

  // Entry store port
  logic                 ram_we;
  logic                 ram_re;
  logic [IDX_W-1:0]     ram_raddr;
  entry_t               ram_wdata;
  entry_t               ram_rdata;

  // Derived terms
  logic                 req_fire;
  logic                 out_free;
  logic [IDX_W-1:0]     ins_slot;
  logic [IDX_W-1:0]     rep_slot;
  logic [IDX_W-1:0]     head_inc;
  logic [CAP_W-1:0]     cap_lim;
  logic                 need_evict;
  logic                 rec_bad;
  logic                 at_max;
  logic                 no_keep;
  logic [SEQ_BITS-1:0]  seq_inc;
  logic [CW-1:0]        after_cw;
  logic [CW-1:0]        cur_cw;
  logic [CW-1:0]        floor_cw;
  logic [CW-1:0]        diff_cw;
  logic                 rep_future;
  logic                 rep_gap;
  logic [CNT_W-1:0]     rep_start;
  logic                 rep_last;

  // Reduce a ring position below DEPTH
  function automatic logic [IDX_W-1:0] wrap_idx(input logic [SUM_W-1:0] s);
    if (s >= SUM_W'(DEPTH)) begin
      return IDX_W'(s - SUM_W'(DEPTH));
    end
    return IDX_W'(s);
  endfunction

  assign req_stall = (state != S_IDLE);
  assign req_fire  = req_valid && !req_stall;
  assign out_free  = !res_valid || !res_stall;

  // Ring positions
  assign ins_slot = wrap_idx(SUM_W'(head) + SUM_W'(count));
  assign rep_slot = wrap_idx(SUM_W'(head) + SUM_W'(k));
  assign head_inc = (head == IDX_W'(DEPTH - 1)) ? '0 : head + 1'b1;

  // Budget check for the pending append
  assign cap_lim = (CAP_W'(max_entries) < CAP_W'(DEPTH)) ? CAP_W'(max_entries)
                                                         : CAP_W'(DEPTH);
  assign need_evict = (count != '0) &&
                      ((CAP_W'(count) + CAP_W'(1) > cap_lim) ||
                       (total > (TOTAL_W'(max_bytes) - TOTAL_W'(req_bytes))));

  // Append qualification
  assign rec_bad = !req_present || (req_bytes == '0);
  assign at_max  = &current_seq;
  assign no_keep = (max_entries == '0) || (max_bytes == '0) ||
                   (MAXB_W'(req_bytes) > max_bytes);
  assign seq_inc = current_seq + 1'b1;

  // Replay window
  assign after_cw   = CW'(req_after);
  assign cur_cw     = CW'(current_seq);
  assign floor_cw   = CW'(floor_seq);
  assign diff_cw    = cur_cw - after_cw;
  assign rep_future = after_cw > cur_cw;
  assign rep_gap    = (after_cw < floor_cw) || (unavail && (after_cw == cur_cw));
  assign rep_start  = (diff_cw >= CW'(count)) ? '0 : count - CNT_W'(diff_cw);
  assign rep_last   = (k == count - CNT_W'(1));

  assign ram_wdata = '{handle: req_handle, size: req_bytes};

  brj_entry_ram #(
    .DEPTH (DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ins_slot),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // Next state and result selection
  always_comb begin
    state_next       = state;
    max_entries_next = max_entries;
    max_bytes_next   = max_bytes;
    current_seq_next = current_seq;
    floor_seq_next   = floor_seq;
    unavail_next     = unavail;
    head_next        = head;
    count_next       = count;
    total_next       = total;
    k_next           = k;
    res_valid_next   = res_valid && res_stall;
    out_load         = 1'b0;
    emit_status      = ST_APPENDED;
    emit_seq         = '0;
    emit_valid       = 1'b0;
    emit_handle      = '0;
    emit_last        = 1'b1;
    ram_we           = 1'b0;
    ram_re           = 1'b0;
    ram_raddr        = head;

    // Register writes are to arrive only while idle; the block does not enforce it
    if (cfg_we) begin
      unique case (cfg_index)
        CFG_MAX_ENTRIES: max_entries_next = cfg_data[MAXE_W-1:0];
        CFG_MAX_BYTES:   max_bytes_next   = cfg_data[MAXB_W-1:0];
        CFG_INIT_SEQ: begin
          current_seq_next = SEQ_BITS'(cfg_data);
          floor_seq_next   = SEQ_BITS'(cfg_data);
          unavail_next     = 1'b0;
          head_next        = '0;
          count_next       = '0;
          total_next       = '0;
        end
        default: ;
      endcase
    end

    unique case (state)
      S_IDLE: begin
        if (req_fire) begin
          state_next = S_DECODE;
        end
      end

      S_DECODE: begin
        unique case (req_action)
          ACT_APPEND: begin
            if (rec_bad) begin
              if (out_free) begin
                out_load    = 1'b1;
                emit_status = ST_INVALID;
                state_next  = S_IDLE;
              end
            end else if (at_max) begin
              if (out_free) begin
                out_load    = 1'b1;
                emit_status = ST_SEQ_OVERFLOW;
                state_next  = S_IDLE;
              end
            end else if (no_keep) begin
              // Drop everything and move the floor up to the new sequence
              if (out_free) begin
                out_load         = 1'b1;
                emit_status      = ST_NOT_RETAINED;
                emit_seq         = SEQ_W'(seq_inc);
                current_seq_next = seq_inc;
                floor_seq_next   = seq_inc;
                head_next        = '0;
                count_next       = '0;
                total_next       = '0;
                state_next       = S_IDLE;
              end
            end else begin
              state_next = S_EVICT_CHK;
            end
          end

          ACT_REPLAY: begin
            if (out_free) begin
              if (rep_future) begin
                out_load    = 1'b1;
                emit_status = ST_FUTURE;
                state_next  = S_IDLE;
              end else if (rep_gap) begin
                out_load    = 1'b1;
                emit_status = ST_GAP;
                state_next  = S_IDLE;
              end else if (rep_start == count) begin
                out_load    = 1'b1;
                emit_status = ST_REPLAY_OK;
                state_next  = S_IDLE;
              end else begin
                k_next     = rep_start;
                state_next = S_REPLAY_RD;
              end
            end
          end

          ACT_INVALIDATE: begin
            if (out_free) begin
              out_load   = 1'b1;
              head_next  = '0;
              count_next = '0;
              total_next = '0;
              state_next = S_IDLE;
              if (at_max) begin
                emit_status    = ST_INVALIDATE_AT_MAX;
                floor_seq_next = current_seq;
                unavail_next   = 1'b1;
              end else begin
                emit_status      = ST_INVALIDATED;
                current_seq_next = seq_inc;
                floor_seq_next   = seq_inc;
                unavail_next     = 1'b0;
              end
            end
          end

          default: state_next = S_IDLE;
        endcase
      end

      S_EVICT_CHK: begin
        if (need_evict) begin
          // Fetch the oldest entry's size
          ram_re     = 1'b1;
          ram_raddr  = head;
          state_next = S_EVICT;
        end else if (out_free) begin
          // Store the new entry at the back of the ring
          ram_we           = 1'b1;
          out_load         = 1'b1;
          emit_status      = ST_APPENDED;
          emit_seq         = SEQ_W'(seq_inc);
          current_seq_next = seq_inc;
          count_next       = count + 1'b1;
          total_next       = total + TOTAL_W'(req_bytes);
          state_next       = S_IDLE;
        end
      end

      S_EVICT: begin
        // Retire the oldest entry; the floor takes its sequence
        floor_seq_next = current_seq - SEQ_BITS'(count - CNT_W'(1));
        total_next     = total - TOTAL_W'(ram_rdata.size);
        head_next      = head_inc;
        count_next     = count - 1'b1;
        state_next     = S_EVICT_CHK;
      end

      S_REPLAY_RD: begin
        ram_re     = 1'b1;
        ram_raddr  = rep_slot;
        state_next = S_REPLAY_OUT;
      end

      S_REPLAY_OUT: begin
        if (out_free) begin
          out_load    = 1'b1;
          emit_status = ST_REPLAY_OK;
          emit_seq    = SEQ_W'(current_seq - SEQ_BITS'(count - CNT_W'(1) - k));
          emit_valid  = 1'b1;
          emit_handle = ram_rdata.handle;
          emit_last   = rep_last;
          if (rep_last) begin
            state_next = S_IDLE;
          end else begin
            k_next     = k + 1'b1;
            state_next = S_REPLAY_RD;
          end
        end
      end

      default: state_next = S_IDLE;
    endcase

    if (out_load) begin
      res_valid_next = 1'b1;
    end
  end

  // State, request latch and result register
  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      max_entries <= MAXE_W'(MAX_ENTRIES_RST);
      max_bytes   <= MAXB_W'(MAX_BYTES_RST);
      current_seq <= '0;
      floor_seq   <= '0;
      unavail     <= 1'b0;
      head        <= '0;
      count       <= '0;
      total       <= '0;
      k           <= '0;
      res_valid   <= 1'b0;
    end else begin
      state       <= state_next;
      max_entries <= max_entries_next;
      max_bytes   <= max_bytes_next;
      current_seq <= current_seq_next;
      floor_seq   <= floor_seq_next;
      unavail     <= unavail_next;
      head        <= head_next;
      count       <= count_next;
      total       <= total_next;
      k           <= k_next;
      res_valid   <= res_valid_next;
    end

    // Capture the request beat
    if (req_fire) begin
      req_action  <= action;
      req_present <= record_present;
      req_handle  <= record_handle;
      req_bytes   <= record_bytes;
      req_after   <= after_sequence;
    end

    // Load a result with the journal state after the step
    if (out_load) begin
      status           <= emit_status;
      sequence_res     <= emit_seq;
      record_valid     <= emit_valid;
      record_out       <= emit_handle;
      last             <= emit_last;
      current_sequence <= SEQ_W'(current_seq_next);
      replay_floor     <= SEQ_W'(floor_seq_next);
      retained_count   <= COUNT_W'(count_next);
      retained_bytes   <= total_next;
    end
  end

endmodule
